FILE: design/smp_pkg.sv
// Package for the stepper move pacer.
// Shared widths, command and register codes, state types and the config struct.
// No dependencies.
package smp_pkg;

    localparam int POS_W  = 12;
    localparam int TIME_W = 24;
    localparam int DLY_W  = 16;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;
    localparam int NEED_W = TIME_W + 1;
    localparam int PROD_W = 30;
    localparam int CNT_W  = $clog2(TIME_W);

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_SET_TARGET = 2'd1,
        CMD_ZERO       = 2'd2,
        CMD_NOP        = 2'd3
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_STEP_DELAY  = 3'd0,
        REG_EDGE_EXTRA  = 3'd1,
        REG_EDGE_ZONE   = 3'd2,
        REG_CYCLE_TIME  = 3'd3,
        REG_TOTAL_STEPS = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CMP,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_MUL,
        DV_SUB,
        DV_DIV,
        DV_DONE
    } t_div_state;

    typedef struct packed {
        logic [DLY_W-1:0]  step_delay_us;
        logic [DLY_W-1:0]  edge_extra_delay_us;
        logic [POS_W-1:0]  edge_zone_steps;
        logic [TIME_W-1:0] cycle_time_us;
        logic [POS_W-1:0]  total_steps;
    } t_cfg;

    typedef struct packed {
        logic             step_pulse;
        logic             direction;
        logic [POS_W-1:0] position;
        logic             reset_line;
        logic             busy_res;
        logic             at_target;
    } t_result;

    function automatic logic [POS_W-1:0] pos_dist(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

FILE: design/smp_in_if.sv
// Input item channel of the stepper move pacer: command and target.
// Depends on smp_pkg.
interface smp_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                command;
    logic [smp_pkg::POS_W-1:0] target;

    modport source (output valid, command, target, input ready);
    modport sink   (input valid, command, target, output ready);
endinterface

FILE: design/smp_out_if.sv
// Result item channel of the stepper move pacer.
// Depends on smp_pkg.
interface smp_out_if;
    logic                      valid;
    logic                      ready;
    logic                      step_pulse;
    logic                      direction;
    logic [smp_pkg::POS_W-1:0] position;
    logic                      reset_line;
    logic                      busy_res;
    logic                      at_target;

    modport source (output valid, step_pulse, direction, position, reset_line,
                    busy_res, at_target, input ready);
    modport sink   (input valid, step_pulse, direction, position, reset_line,
                    busy_res, at_target, output ready);
endinterface

FILE: design/smp_cfg_if.sv
// Configuration write channel of the stepper move pacer: register index and data.
// Depends on smp_pkg.
interface smp_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [smp_pkg::IDX_W-1:0] index;
    logic [smp_pkg::CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/smp_xdiv.sv
// Extra delay unit: bit-serial multiply of the edge and distance terms, then a
// restoring divide of the remaining time by the distance, one bit per cycle.
// Depends on smp_pkg.
module smp_xdiv (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [smp_pkg::POS_W-1:0] i_dist,
    input  smp_pkg::t_cfg             i_cfg,
    output logic                      o_done,
    output logic [smp_pkg::TIME_W-1:0] o_quot
);
    import smp_pkg::*;

    t_div_state r_state, n_state;

    logic [POS_W-1:0]  r_mq1, r_mq2, r_div, r_part;
    logic [PROD_W-1:0] r_mc1, r_mc2, r_acc;
    logic [TIME_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;

    logic [PROD_W-1:0] w_cycle;
    logic              w_nonpos;
    logic [POS_W:0]    w_trial;
    logic              w_ge;

    assign w_cycle  = {{(PROD_W-TIME_W){1'b0}}, i_cfg.cycle_time_us};
    assign w_nonpos = (r_acc >= w_cycle);
    assign w_trial  = {r_part, r_rem[TIME_W-1]};
    assign w_ge     = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE: if (i_start) n_state = DV_MUL;
            DV_MUL:  if (r_cnt == CNT_W'(POS_W-1)) n_state = DV_SUB;
            DV_SUB:  n_state = w_nonpos ? DV_DONE : DV_DIV;
            DV_DIV:  if (r_cnt == CNT_W'(TIME_W-1)) n_state = DV_DONE;
            DV_DONE: n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == DV_DONE);
        o_quot = r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                r_mq1 <= i_cfg.edge_zone_steps;
                r_mq2 <= i_dist;
                r_div <= i_dist;
                r_mc1 <= {{(PROD_W-DLY_W-1){1'b0}}, i_cfg.edge_extra_delay_us, 1'b0};
                r_mc2 <= {{(PROD_W-DLY_W){1'b0}}, i_cfg.step_delay_us};
                r_acc <= '0;
                r_cnt <= '0;
            end
            DV_MUL: begin
                r_acc <= r_acc + (r_mq1[0] ? r_mc1 : '0) + (r_mq2[0] ? r_mc2 : '0);
                r_mq1 <= r_mq1 >> 1;
                r_mq2 <= r_mq2 >> 1;
                r_mc1 <= r_mc1 << 1;
                r_mc2 <= r_mc2 << 1;
                r_cnt <= r_cnt + 1'b1;
            end
            DV_SUB: begin
                r_rem  <= w_nonpos ? '0 : (i_cfg.cycle_time_us - r_acc[TIME_W-1:0]);
                r_part <= '0;
                r_cnt  <= '0;
            end
            DV_DIV: begin
                r_part <= w_ge ? POS_W'(w_trial - {1'b0, r_div}) : w_trial[POS_W-1:0];
                r_rem  <= {r_rem[TIME_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == DV_IDLE))
        else $error("extra delay unit started while busy");

    a_dist_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_dist != '0))
        else $error("extra delay unit started with zero distance");

    a_part_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == DV_DIV) |-> (r_part < r_div))
        else $error("partial remainder not below divisor");

endmodule

FILE: design/stepper_move_pacer.sv
// Stepper move pacer top level: command sequencer, move and zeroing state, config
// registers and a one-item output register. Depends on smp_pkg, the three
// channel interfaces and smp_xdiv.
//
// Each accepted item gives exactly one result item. A tick passes through the
// EXEC, CMP and EMIT states to the result register; zeroing, no-op and an
// ignored or zero-distance set-target pass through EXEC and EMIT only. A
// set-target with a nonzero distance waits in DIV for the extra delay unit: a
// bit-serial multiply, a subtract step, a restoring divide and a done step.
// When the remaining time is not positive the divide is skipped. A new item is
// accepted as soon as the previous one has been placed in the output register,
// even while that result still waits to be taken. Config writes are taken
// every cycle.
module stepper_move_pacer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smp_in_if.sink    i_in,
    smp_out_if.source o_out,
    smp_cfg_if.sink   i_cfg
);
    import smp_pkg::*;

    t_state r_state, n_state;

    t_cfg r_cfg;

    logic [POS_W-1:0]  r_cur, r_tgt_pos, r_start, r_zdone;
    logic              r_dir, r_zeroing, r_reset_out;
    logic [TIME_W-1:0] r_extra, r_elapsed;

    t_cmd              r_cmd;
    logic [POS_W-1:0]  r_tgt;
    logic [NEED_W-1:0] r_need;
    logic              r_zone;
    logic              r_pulse;

    logic    r_ovalid;
    t_result r_out;

    logic              w_in_ready, w_div_start, w_out_load, w_div_done;
    logic [TIME_W-1:0] w_quot;
    logic [POS_W-1:0]  w_dist, w_zdone_nx;
    logic [NEED_W-1:0] w_need;
    logic              w_due, w_step, w_zone;

    assign w_dist     = pos_dist(r_tgt, r_cur);
    assign w_zone     = (r_tgt_pos != '0) &&
                        ((pos_dist(r_cur, r_tgt_pos) < r_cfg.edge_zone_steps) ||
                         (pos_dist(r_start, r_cur) < r_cfg.edge_zone_steps));
    assign w_need     = r_need + (r_zone ? NEED_W'(r_cfg.edge_extra_delay_us) : '0);
    assign w_due      = ({1'b0, r_elapsed} >= w_need);
    assign w_step     = w_due && (r_zeroing || (r_cur != r_tgt_pos));
    assign w_zdone_nx = r_zdone + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in.valid) n_state = ST_EXEC;
            ST_EXEC: begin
                case (r_cmd)
                    CMD_TICK:       n_state = ST_CMP;
                    CMD_SET_TARGET: n_state = (!r_zeroing && w_dist != '0) ? ST_DIV : ST_EMIT;
                    default:        n_state = ST_EMIT;
                endcase
            end
            ST_CMP:  n_state = ST_EMIT;
            ST_DIV:  if (w_div_done) n_state = ST_EMIT;
            ST_EMIT: if (!r_ovalid || o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = (r_state == ST_IDLE);
        w_div_start = (r_state == ST_EXEC) && (r_cmd == CMD_SET_TARGET) &&
                      !r_zeroing && (w_dist != '0);
        w_out_load  = (r_state == ST_EMIT) && (!r_ovalid || o_out.ready);
    end

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    smp_xdiv u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dist  (w_dist),
        .i_cfg   (r_cfg),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_delay_us       <= DLY_W'(1000);
            r_cfg.edge_extra_delay_us <= '0;
            r_cfg.edge_zone_steps     <= '0;
            r_cfg.cycle_time_us       <= '0;
            r_cfg.total_steps         <= POS_W'(4095);
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_STEP_DELAY:  r_cfg.step_delay_us       <= i_cfg.data[DLY_W-1:0];
                REG_EDGE_EXTRA:  r_cfg.edge_extra_delay_us <= i_cfg.data[DLY_W-1:0];
                REG_EDGE_ZONE:   r_cfg.edge_zone_steps     <= i_cfg.data[POS_W-1:0];
                REG_CYCLE_TIME:  r_cfg.cycle_time_us       <= i_cfg.data[TIME_W-1:0];
                REG_TOTAL_STEPS: r_cfg.total_steps         <= i_cfg.data[POS_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // move and zeroing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_tgt_pos   <= '0;
            r_start     <= '0;
            r_dir       <= 1'b0;
            r_extra     <= '0;
            r_elapsed   <= '0;
            r_zdone     <= '0;
            r_zeroing   <= 1'b0;
            r_reset_out <= 1'b0;
        end else begin
            case (r_state)
                ST_EXEC: begin
                    case (r_cmd)
                        CMD_TICK: begin
                            if (r_elapsed != '1) r_elapsed <= r_elapsed + 1'b1;
                        end
                        CMD_SET_TARGET: begin
                            if (!r_zeroing) begin
                                r_tgt_pos <= r_tgt;
                                r_start   <= r_cur;
                                r_dir     <= !(r_tgt < r_cur);
                                if (w_dist == '0) r_extra <= '0;
                            end
                        end
                        CMD_ZERO: begin
                            if (!r_zeroing) begin
                                r_reset_out <= 1'b1;
                                r_zdone     <= '0;
                                if (r_cfg.total_steps == '0) begin
                                    r_cur     <= '0;
                                    r_dir     <= 1'b1;
                                    r_zeroing <= 1'b0;
                                end else begin
                                    r_dir     <= 1'b0;
                                    r_zeroing <= 1'b1;
                                end
                            end
                        end
                        default: r_elapsed <= r_elapsed;
                    endcase
                end
                ST_CMP: begin
                    if (w_step) begin
                        r_elapsed <= '0;
                        if (r_zeroing) begin
                            r_zdone <= w_zdone_nx;
                            if (w_zdone_nx >= r_cfg.total_steps) begin
                                r_cur     <= '0;
                                r_dir     <= 1'b1;
                                r_zeroing <= 1'b0;
                            end
                        end else if (r_dir) begin
                            r_cur <= r_cur + 1'b1;
                        end else begin
                            r_cur <= r_cur - 1'b1;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_done) r_extra <= w_quot;
                end
                default: r_extra <= r_extra;
            endcase
        end
    end

    // per-item scratch
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_cmd <= t_cmd'(i_in.command);
            r_tgt <= i_in.target;
        end
        if (r_state == ST_EXEC) begin
            r_pulse <= 1'b0;
            r_need  <= NEED_W'(r_cfg.step_delay_us) + NEED_W'(r_extra);
            r_zone  <= w_zone;
        end else if (r_state == ST_CMP) begin
            r_pulse <= w_step;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.step_pulse <= r_pulse;
            r_out.direction  <= r_dir;
            r_out.position   <= r_cur;
            r_out.reset_line <= r_reset_out;
            r_out.busy_res   <= r_zeroing;
            r_out.at_target  <= (r_cur == r_tgt_pos);
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.step_pulse = r_out.step_pulse;
    assign o_out.direction  = r_out.direction;
    assign o_out.position   = r_out.position;
    assign o_out.reset_line = r_out.reset_line;
    assign o_out.busy_res   = r_out.busy_res;
    assign o_out.at_target  = r_out.at_target;

    a_zero_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zeroing |=> (r_cur == $past(r_cur)) || ((r_cur == '0) && !r_zeroing))
        else $error("position moved during zeroing");

    a_reset_line_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reset_out |=> r_reset_out)
        else $error("reset line dropped");

    a_zero_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_zeroing) && $past(i_rst_n)) |-> (r_dir && (r_cur == '0)))
        else $error("zeroing ended without home position");

    a_pulse_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && r_pulse) |-> (r_cmd == CMD_TICK))
        else $error("step pulse on a non-tick item");

endmodule
